// ----- rtl/fmpc_pkg.sv -----
// Shared widths, constants and types of the Fibonacci residue checker.
package fmpc_pkg;

  localparam int unsigned DATA_W  = 31;
  localparam int unsigned IDX_W   = 31;
  localparam int unsigned GUESS_W = 6;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned EXP_W   = IDX_W + 1;
  localparam int unsigned STEP_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] MOD_RESET = DATA_W'(1000000007);

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_CHECK,
    CS_SQCHK,
    CS_MUL_START,
    CS_MUL_WAIT,
    CS_DONE
  } core_state_e;

  // Partial products of one symmetric 2x2 matrix product, in issue order.
  typedef enum logic [2:0] {
    ST_P00,
    ST_P11,
    ST_P01,
    ST_P13,
    ST_P33
  } step_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] mcand;
    logic [DATA_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

endpackage

// ----- rtl/fmpc_modmul.sv -----
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module fmpc_modmul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fmpc_pkg::mul_req_t        req_i,
  input  logic [fmpc_pkg::DATA_W-1:0] mod_i,
  output logic                      done_o,
  output logic [fmpc_pkg::DATA_W-1:0] prod_o
);
  import fmpc_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0] mcand_q, mcand_d;
  logic [DATA_W-1:0] mplier_q, mplier_d;
  logic [DATA_W-1:0] prod_q, prod_d;
  logic [DATA_W+2:0] sum, sub1, sub2;
  logic [DATA_W-1:0] step_res;

  // Doubling plus the selected multiplicand lies below three times the modulus,
  // so the three candidates are formed side by side and the smallest
  // non-negative one is kept.
  always_comb begin
    sum  = {2'b00, prod_q, 1'b0} + {3'b000, (mplier_q[DATA_W-1] ? mcand_q : '0)};
    sub1 = sum - {3'b000, mod_i};
    sub2 = sum - {2'b00, mod_i, 1'b0};
    if (!sub2[DATA_W+2]) begin
      step_res = sub2[DATA_W-1:0];
    end else if (!sub1[DATA_W+2]) begin
      step_res = sub1[DATA_W-1:0];
    end else begin
      step_res = sum[DATA_W-1:0];
    end
  end

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    prod_d   = prod_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = STEP_W'(DATA_W - 1);
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
      prod_d   = '0;
    end else if (busy_q) begin
      prod_d   = step_res;
      mplier_d = {mplier_q[DATA_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    prod_q   <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ----- rtl/fmpc_core.sv -----
// Sequencer for square-and-multiply of the Fibonacci matrix on the shared multiplier.
module fmpc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fmpc_pkg::IDX_W-1:0]  index_i,
  input  logic [fmpc_pkg::DATA_W-1:0] mod_i,
  input  logic                        res_ack_i,
  input  logic                        mul_done_i,
  input  logic [fmpc_pkg::DATA_W-1:0] mul_prod_i,
  output fmpc_pkg::mul_req_t          mul_req_o,
  output fmpc_pkg::core_stat_t        stat_o,
  output logic [fmpc_pkg::DATA_W-1:0] residue_o
);
  import fmpc_pkg::*;

  core_state_e       state_q, state_d;
  step_e             step_q, step_d;
  logic              sq_q, sq_d;
  logic [EXP_W-1:0]  exp_q, exp_d;
  // Powers of the matrix stay symmetric, so each keeps three entries:
  // upper left, off diagonal, lower right.
  logic [DATA_W-1:0] a0_q, a0_d, a1_q, a1_d, a3_q, a3_d;
  logic [DATA_W-1:0] b0_q, b0_d, b1_q, b1_d, b3_q, b3_d;
  logic [DATA_W-1:0] t0_q, t0_d, t1_q, t1_d, c0_q, c0_d, c1_q, c1_d;
  logic [DATA_W-1:0] one_m;
  logic [DATA_W-1:0] op_0, op_1, op_3;
  logic [DATA_W-1:0] add_x, add_res;
  logic [DATA_W:0]   add_sum;

  assign one_m = (mod_i == DATA_W'(1)) ? '0 : DATA_W'(1);

  // Left operand is the base itself when squaring.
  assign op_0 = sq_q ? b0_q : a0_q;
  assign op_1 = sq_q ? b1_q : a1_q;
  assign op_3 = sq_q ? b3_q : a3_q;

  assign add_x   = (step_q == ST_P33) ? t1_q : t0_q;
  assign add_sum = {1'b0, add_x} + {1'b0, mul_prod_i};
  always_comb begin
    if (add_sum >= {1'b0, mod_i}) begin
      add_res = DATA_W'(add_sum - {1'b0, mod_i});
    end else begin
      add_res = add_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    sq_q   <= sq_d;
    exp_q  <= exp_d;
    a0_q   <= a0_d;
    a1_q   <= a1_d;
    a3_q   <= a3_d;
    b0_q   <= b0_d;
    b1_q   <= b1_d;
    b3_q   <= b3_d;
    t0_q   <= t0_d;
    t1_q   <= t1_d;
    c0_q   <= c0_d;
    c1_q   <= c1_d;
  end

  always_comb begin
    state_d          = state_q;
    step_d           = step_q;
    sq_d             = sq_q;
    exp_d            = exp_q;
    a0_d             = a0_q;
    a1_d             = a1_q;
    a3_d             = a3_q;
    b0_d             = b0_q;
    b1_d             = b1_q;
    b3_d             = b3_q;
    t0_d             = t0_q;
    t1_d             = t1_q;
    c0_d             = c0_q;
    c1_d             = c1_q;
    mul_req_o.start  = 1'b0;
    mul_req_o.mcand  = op_0;
    mul_req_o.mplier = b0_q;
    stat_o.idle      = 1'b0;
    stat_o.res_valid = 1'b0;

    unique case (step_q)
      ST_P00: begin
        mul_req_o.mcand  = op_0;
        mul_req_o.mplier = b0_q;
      end
      ST_P11: begin
        mul_req_o.mcand  = op_1;
        mul_req_o.mplier = b1_q;
      end
      ST_P01: begin
        mul_req_o.mcand  = op_0;
        mul_req_o.mplier = b1_q;
      end
      ST_P13: begin
        mul_req_o.mcand  = op_1;
        mul_req_o.mplier = b3_q;
      end
      ST_P33: begin
        mul_req_o.mcand  = op_3;
        mul_req_o.mplier = b3_q;
      end
      default: begin
        mul_req_o.mcand  = op_0;
        mul_req_o.mplier = b0_q;
      end
    endcase

    unique case (state_q)
      CS_IDLE: begin
        stat_o.idle = 1'b1;
        if (start_i) begin
          exp_d   = {1'b0, index_i} + EXP_W'(1);
          b0_d    = one_m;
          b1_d    = one_m;
          b3_d    = '0;
          a0_d    = one_m;
          a1_d    = '0;
          a3_d    = one_m;
          state_d = CS_CHECK;
        end
      end
      CS_CHECK: begin
        if (exp_q == '0) begin
          state_d = CS_DONE;
        end else if (exp_q[0]) begin
          sq_d    = 1'b0;
          step_d  = ST_P00;
          state_d = CS_MUL_START;
        end else begin
          state_d = CS_SQCHK;
        end
      end
      CS_SQCHK: begin
        // The last squaring would never be used, so it is skipped.
        if ((exp_q >> 1) != '0) begin
          sq_d    = 1'b1;
          step_d  = ST_P00;
          state_d = CS_MUL_START;
        end else begin
          exp_d   = exp_q >> 1;
          state_d = CS_CHECK;
        end
      end
      CS_MUL_START: begin
        mul_req_o.start = 1'b1;
        state_d         = CS_MUL_WAIT;
      end
      CS_MUL_WAIT: begin
        if (mul_done_i) begin
          state_d = CS_MUL_START;
          unique case (step_q)
            ST_P00: begin
              t0_d   = mul_prod_i;
              step_d = ST_P11;
            end
            ST_P11: begin
              t1_d   = mul_prod_i;
              c0_d   = add_res;
              step_d = ST_P01;
            end
            ST_P01: begin
              t0_d   = mul_prod_i;
              step_d = ST_P13;
            end
            ST_P13: begin
              c1_d   = add_res;
              step_d = ST_P33;
            end
            ST_P33: begin
              if (sq_q) begin
                b0_d    = c0_q;
                b1_d    = c1_q;
                b3_d    = add_res;
                exp_d   = exp_q >> 1;
                state_d = CS_CHECK;
              end else begin
                a0_d    = c0_q;
                a1_d    = c1_q;
                a3_d    = add_res;
                state_d = CS_SQCHK;
              end
            end
            default: begin
              step_d = ST_P00;
            end
          endcase
        end
      end
      CS_DONE: begin
        stat_o.res_valid = 1'b1;
        if (res_ack_i) begin
          state_d = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign residue_o = a1_q;

endmodule

// ----- rtl/fibonacci_mod_popcount_check.sv -----
// Top level: Fibonacci residue by matrix powering, with a bit-count check.
//
// Usage: an input beat carries index_i (n) and guess_i. The block returns one
// output beat per input beat with F(n+1) mod the configured modulus, the count
// of one bits in that residue and a flag that the count equals the guess.
// Both channels move a beat at a clock edge with valid high and stall low.
// The modulus register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while no beat is in flight, as the block does not enforce this;
// values below two act as a modulus of one. Each 2x2 matrix product takes five
// modular multiplies on the one bit-serial multiplier. With e = n+1, an item
// needs popcount(e) + bitlength(e) - 1 matrix products. Items are processed one
// at a time; in_stall_o is high while an item is being computed.
// The result sits in an output register, so a new input beat is taken while
// the receiver stalls the previous result; the core then waits with its
// finished result until that register frees up.
// Reset clears all handshake state and loads the modulus 1000000007.
module fibonacci_mod_popcount_check #(
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fmpc_pkg::IDX_W-1:0]   index_i,
  input  logic [fmpc_pkg::GUESS_W-1:0] guess_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fmpc_pkg::DATA_W-1:0]  fib_residue_o,
  output logic [fmpc_pkg::CNT_W-1:0]   bit_count_o,
  output logic                         match_o,
  input  logic                         cfg_we_i,
  input  logic [fmpc_pkg::DATA_W-1:0]  cfg_wdata_i
);
  import fmpc_pkg::*;

  function automatic logic [CNT_W-1:0] ones31(input logic [DATA_W-1:0] v);
    logic [31:0] x;
    logic [7:0]  s;
    x = {1'b0, v};
    x = x - ((x >> 1) & 32'h5555_5555);
    x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
    x = (x + (x >> 4)) & 32'h0F0F_0F0F;
    s = x[7:0] + x[15:8] + x[23:16] + x[31:24];
    return s[CNT_W-1:0];
  endfunction

  logic [DATA_W-1:0]  mod_q, mod_d;
  logic [DATA_W-1:0]  mod_eff;
  logic [GUESS_W-1:0] guess_q, guess_d;
  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  res_q, res_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               match_q, match_d;
  logic [IDX_W-1:0]   index_used;
  logic               accept;
  logic               res_ack;
  core_stat_t         core_stat;
  mul_req_t           mul_req;
  logic               mul_done;
  logic [DATA_W-1:0]  mul_prod;
  logic [DATA_W-1:0]  core_res;

  always_comb begin
    for (int i = 0; i < IDX_W; i++) begin
      index_used[i] = index_i[i] & (i < INDEX_BITS);
    end
  end

  assign mod_eff    = (mod_q < DATA_W'(2)) ? DATA_W'(1) : mod_q;
  assign in_stall_o = !core_stat.idle;
  assign accept     = in_valid_i && !in_stall_o;
  assign res_ack    = core_stat.res_valid && (!out_valid_q || !out_stall_i);

  fmpc_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .mod_i  (mod_eff),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  fmpc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .index_i    (index_used),
    .mod_i      (mod_eff),
    .res_ack_i  (res_ack),
    .mul_done_i (mul_done),
    .mul_prod_i (mul_prod),
    .mul_req_o  (mul_req),
    .stat_o     (core_stat),
    .residue_o  (core_res)
  );

  always_comb begin
    mod_d       = cfg_we_i ? cfg_wdata_i : mod_q;
    guess_d     = accept ? guess_i : guess_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    cnt_d       = cnt_q;
    match_d     = match_q;
    if (res_ack) begin
      out_valid_d = 1'b1;
      res_d       = core_res;
      cnt_d       = ones31(core_res);
      match_d     = ({1'b0, ones31(core_res)} == guess_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= MOD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      mod_q       <= mod_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    guess_q <= guess_d;
    res_q   <= res_d;
    cnt_q   <= cnt_d;
    match_q <= match_d;
  end

  assign out_valid_o   = out_valid_q;
  assign fib_residue_o = res_q;
  assign bit_count_o   = cnt_q;
  assign match_o       = match_q;

`ifndef SYNTHESIS
  // An accepted beat keeps the core busy on the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("core not busy after accepting a beat");

  // The output register is only loaded from a finished core result.
  a_ack_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ack |-> (core_stat.res_valid && !core_stat.idle))
    else $error("result taken from core without a finished result");

  // A zero bit count goes with a zero residue and nothing else.
  a_count_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((bit_count_o == '0) == (fib_residue_o == '0)))
    else $error("bit count disagrees with residue");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the Fibonacci residue and bit-count checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fmpc_pkg::*;

  localparam logic [DATA_W-1:0] MOD_MAX = '1;
  localparam int unsigned PRESSURE_AT = 150;
  localparam int unsigned PRESSURE_CYCLES = 40000;
  localparam int unsigned PRINT_LIMIT = 50;

  typedef struct {
    logic [DATA_W-1:0] residue;
    logic [CNT_W-1:0]  count;
    logic              hit;
  } fib_result_t;

  typedef struct {
    longint unsigned e00, e01, e10, e11;
  } mat2_t;

  typedef struct {
    logic [DATA_W-1:0]  modulus;
    logic [IDX_W-1:0]   index;
    logic [GUESS_W-1:0] guess;
    bit                 known;
    fib_result_t        want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [IDX_W-1:0]    index_i = '0;
  logic [GUESS_W-1:0]  guess_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [DATA_W-1:0]   fib_residue_o;
  logic [CNT_W-1:0]    bit_count_o;
  logic                match_o;
  logic                cfg_we_i = 1'b0;
  logic [DATA_W-1:0]   cfg_wdata_i = '0;

  fib_result_t pending_results[$];
  stim_row_t   directed_rows[$];
  logic [DATA_W-1:0] modulus_now = MOD_RESET;

  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned moduli_used = 0;

  fibonacci_mod_popcount_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .index_i       (index_i),
    .guess_i       (guess_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .fib_residue_o (fib_residue_o),
    .bit_count_o   (bit_count_o),
    .match_o       (match_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #400_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic mat2_t mat2_mul(input mat2_t x, input mat2_t y, input longint unsigned m);
    mat2_t z;
    z.e00 = (((x.e00 * y.e00) % m) + ((x.e01 * y.e10) % m)) % m;
    z.e01 = (((x.e00 * y.e01) % m) + ((x.e01 * y.e11) % m)) % m;
    z.e10 = (((x.e10 * y.e00) % m) + ((x.e11 * y.e10) % m)) % m;
    z.e11 = (((x.e10 * y.e01) % m) + ((x.e11 * y.e11) % m)) % m;
    return z;
  endfunction

  // Square-and-multiply of [[1,1],[1,0]] to the power index+1; a modulus below
  // two behaves as one.
  function automatic fib_result_t predict_fib(input logic [IDX_W-1:0] idx,
                                              input logic [GUESS_W-1:0] g);
    mat2_t acc, base;
    longint unsigned m, e;
    fib_result_t r;
    m = (modulus_now < 2) ? 64'd1 : 64'(modulus_now);
    e = 64'(idx) + 64'd1;
    base.e00 = 1 % m; base.e01 = 1 % m; base.e10 = 1 % m; base.e11 = 0;
    acc.e00 = 1 % m;  acc.e01 = 0;      acc.e10 = 0;      acc.e11 = 1 % m;
    while (e != 0) begin
      if (e[0]) acc = mat2_mul(acc, base, m);
      base = mat2_mul(base, base, m);
      e = e >> 1;
    end
    r.residue = acc.e01[DATA_W-1:0];
    r.count = CNT_W'($countones(r.residue));
    r.hit = (GUESS_W'(r.count) == g);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] draw_index();
    int unsigned pick, width;
    pick = $urandom_range(0, 99);
    if (pick == 0) return '1;
    if (pick < 6) return IDX_W'($urandom);
    width = (pick < 75) ? $urandom_range(1, 7) : $urandom_range(8, 16);
    return IDX_W'($urandom & ((32'd1 << width) - 32'd1));
  endfunction

  function automatic void add_row(input logic [DATA_W-1:0] modulus, input logic [IDX_W-1:0] idx,
                                  input logic [GUESS_W-1:0] g, input bit known,
                                  input logic [DATA_W-1:0] residue, input logic [CNT_W-1:0] count,
                                  input logic hit);
    stim_row_t row;
    row.modulus = modulus;
    row.index = idx;
    row.guess = g;
    row.known = known;
    row.want.residue = residue;
    row.want.count = count;
    row.want.hit = hit;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    fib_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result beat, residue", fib_residue_o, 0);
      return;
    end
    want = pending_results.pop_front();
    if (fib_residue_o !== want.residue) report_mismatch("fib_residue", fib_residue_o, want.residue);
    if (bit_count_o !== want.count) report_mismatch("bit_count", bit_count_o, want.count);
    if (match_o !== want.hit) report_mismatch("match", match_o, want.hit);
    if (match_o === 1'b1) hits_seen++;
  endtask

  // Drives one input beat after a random gap and returns at the edge that takes it.
  task automatic send_beat(input logic [IDX_W-1:0] idx, input logic [GUESS_W-1:0] g,
                           input fib_result_t want);
    int unsigned gap;
    gap = (beats_sent % 48 < 12) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    index_i <= idx;
    guess_i <= g;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(want);
    beats_sent++;
  endtask

  // The modulus only changes once every outstanding result has come back.
  task automatic set_modulus(input logic [DATA_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    modulus_now = value;
    moduli_used++;
  endtask

  task automatic run_random_phase(input logic [DATA_W-1:0] value, input int unsigned beats);
    logic [IDX_W-1:0] idx;
    logic [GUESS_W-1:0] g;
    fib_result_t hint;
    set_modulus(value);
    repeat (beats) begin
      idx = draw_index();
      hint = predict_fib(idx, '0);
      // Half the guesses are the true count so that matches show up often.
      g = ($urandom_range(0, 1) == 1) ? GUESS_W'(hint.count) : GUESS_W'($urandom_range(0, 63));
      send_beat(idx, g, predict_fib(idx, g));
    end
  endtask

  initial begin : result_side
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        check_result();
        results_seen++;
        if (results_seen == PRESSURE_AT) hold = PRESSURE_CYCLES;
        else hold = (results_seen % 40 < 10) ? 0 : $urandom_range(0, 16);
      end else if (out_valid_o && hold != 0) begin
        hold--;
      end
      out_stall_i <= (hold != 0);
    end
  end

  initial begin : stimulus
    fib_result_t want;
    add_row(MOD_RESET, 0, 1, 1, 1, 1, 1);
    add_row(MOD_RESET, 1, 0, 1, 1, 1, 0);
    add_row(MOD_RESET, 2, 1, 1, 2, 1, 1);
    add_row(MOD_RESET, 3, 2, 1, 3, 2, 1);
    add_row(MOD_RESET, 4, 2, 1, 5, 2, 1);
    add_row(MOD_RESET, 9, 63, 1, 55, 5, 0);
    add_row(MOD_RESET, '1, 0, 0, 0, 0, 0);
    add_row(MOD_RESET, 31'h7FFF_FFFE, 32, 0, 0, 0, 0);
    add_row(MOD_RESET, 31'h5555_5555, 6'h2A, 0, 0, 0, 0);
    add_row(MOD_RESET, 31'h2AAA_AAAA, 6'h15, 0, 0, 0, 0);
    add_row(MOD_MAX, '1, 31, 0, 0, 0, 0);
    add_row(MOD_MAX, 45, 31, 0, 0, 0, 0);
    add_row(2, 0, 1, 1, 1, 1, 1);
    add_row(2, 2, 0, 1, 0, 0, 1);
    add_row(2, '1, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 1, 0, 0, 1);
    add_row(1, '1, 1, 1, 0, 0, 0);
    add_row(0, 5, 0, 1, 0, 0, 1);
    add_row(0, 1234, 63, 1, 0, 0, 0);
    add_row(3, 7, 1, 0, 0, 0, 0);
    add_row(1000, 999, 7, 0, 0, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].modulus != modulus_now) set_modulus(directed_rows[i].modulus);
      want = directed_rows[i].known ? directed_rows[i].want
                                    : predict_fib(directed_rows[i].index, directed_rows[i].guess);
      send_beat(directed_rows[i].index, directed_rows[i].guess, want);
    end

    run_random_phase(MOD_MAX, 160);
    run_random_phase(DATA_W'($urandom_range(2, 32'h7FFF_FFFF)), 160);
    run_random_phase(DATA_W'($urandom_range(2, 64)), 160);
    run_random_phase(1, 40);
    run_random_phase(31'h4000_0000, 160);
    run_random_phase(MOD_RESET, 100);
    run_random_phase(DATA_W'($urandom), 100);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("summary: %0d input beats and %0d result beats over %0d modulus writes",
             beats_sent, results_seen, moduli_used);
    $display("summary: %0d results flagged a matching bit count, %0d mismatches",
             hits_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
